/* sv/isst_pkg.sv */
// Shared codes, register indexes and widths for the interval sequence task timer.
package isst_pkg;

   localparam int TABLE_DEPTH_DEF = 8;

   localparam int FUNC_W  = 3;
   localparam int TIME_W  = 32;
   localparam int POS_W   = 3;
   localparam int CNT_W   = 32;
   localparam int REP_W   = 16;
   localparam int LEN_W   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // func codes
   localparam logic [FUNC_W-1:0] FUNC_CALL    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ENABLE  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DISABLE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESUME  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_RESET   = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEQ_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_START_DELAY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVALS_01 = 3'd4;

   // mode bits
   localparam int MODE_SPANNING = 0;
   localparam int MODE_SUSP_END = 1;

   localparam logic [REP_W-1:0] REP_MAX = '1;

endpackage

/* sv/interval_sequence_task_timer.sv */
// Interval sequence task timer: state update, config registers and result register.
// Each accepted word's result is registered and shows at the rsp_ outputs.
// Throughput: one word per cycle while not stalled; the state update compares elapsed
// time against the start delay or the current table interval, plus counter updates.
// Input is stalled only while a result waits and rsp_stall is high.
// Synchronous active-high reset restores config defaults, an enabled idle timer.
module interval_sequence_task_timer #(
   parameter int TABLE_DEPTH = isst_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [isst_pkg::FUNC_W-1:0]       req_func,
   input  logic [isst_pkg::TIME_W-1:0]       req_now_us,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_run,
   output logic                              rsp_is_enabled,
   output logic                              rsp_is_suspended,
   output logic                              rsp_has_ended,
   output logic [isst_pkg::POS_W-1:0]        rsp_position,
   output logic [isst_pkg::CNT_W-1:0]        rsp_exec_total,
   output logic [isst_pkg::CNT_W-1:0]        rsp_interval_total,
   output logic [isst_pkg::CNT_W-1:0]        rsp_sleep_total,
   output logic [isst_pkg::REP_W-1:0]        rsp_repeat_total,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [isst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [isst_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // config
   logic [1:0]                      mode_ff;
   logic [isst_pkg::LEN_W-1:0]      seq_length_ff;
   logic [isst_pkg::REP_W-1:0]      repeat_count_ff;
   logic [isst_pkg::TIME_W-1:0]     start_delay_ff;
   logic [isst_pkg::TIME_W-1:0]     table_ff [TABLE_DEPTH];

   // timer state
   logic                            enabled_ff, enabled_in;
   logic                            started_ff, started_in;
   logic                            delay_entered_ff, delay_entered_in;
   logic                            cycle_ff, cycle_in;
   logic                            suspended_ff, suspended_in;
   logic                            ended_ff, ended_in;
   logic                            level_ff, level_in;
   logic [isst_pkg::TIME_W-1:0]     entry_ff, entry_in;
   logic [isst_pkg::POS_W-1:0]      index_ff, index_in;
   logic [isst_pkg::CNT_W-1:0]      exec_ff, exec_in;
   logic [isst_pkg::CNT_W-1:0]      interval_ff, interval_in;
   logic [isst_pkg::CNT_W-1:0]      sleep_ff, sleep_in;
   logic [isst_pkg::REP_W-1:0]      repeat_ff, repeat_in;
   logic                            run_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_run_ff;
   logic                            rsp_enabled_ff;
   logic                            rsp_suspended_ff;
   logic                            rsp_ended_ff;
   logic [isst_pkg::POS_W-1:0]      rsp_position_ff;
   logic [isst_pkg::CNT_W-1:0]      rsp_exec_ff;
   logic [isst_pkg::CNT_W-1:0]      rsp_interval_ff;
   logic [isst_pkg::CNT_W-1:0]      rsp_sleep_ff;
   logic [isst_pkg::REP_W-1:0]      rsp_repeat_ff;

   logic                            accept;
   logic                            spanning;
   logic [isst_pkg::LEN_W-1:0]      eff_len;
   logic [isst_pkg::TIME_W-1:0]     elapsed;
   logic [isst_pkg::TIME_W-1:0]     cur_interval;
   logic                            interval_done;
   logic [isst_pkg::POS_W-1:0]      next_index;
   logic                            wrapped;
   logic [2:0]                      half_len;
   logic [18:0]                     odd_prod;
   logic [19:0]                     even_prod;
   logic [isst_pkg::CNT_W-1:0]      span_end;
   logic                            hold;
   logic                            do_clear;
   logic                            finite;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign spanning = mode_ff[isst_pkg::MODE_SPANNING];
   assign finite   = (repeat_count_ff != '0);

   always_comb begin
      if (seq_length_ff == '0)
         eff_len = isst_pkg::LEN_W'(1);
      else if (seq_length_ff > isst_pkg::LEN_W'(TABLE_DEPTH))
         eff_len = isst_pkg::LEN_W'(TABLE_DEPTH);
      else
         eff_len = seq_length_ff;
   end

   assign elapsed       = req_now_us - entry_ff;
   assign cur_interval  = table_ff[index_ff[IDX_W-1:0]];
   assign interval_done = (elapsed >= cur_interval);

   // position advance; wraps when at or past the last interval in use
   always_comb begin
      if ({1'b0, index_ff} < eff_len - isst_pkg::LEN_W'(1)) begin
         next_index = index_ff + isst_pkg::POS_W'(1);
         wrapped    = 1'b0;
      end else begin
         next_index = '0;
         wrapped    = 1'b1;
      end
   end

   // end count for spanning mode
   assign half_len  = 3'((eff_len + isst_pkg::LEN_W'(1)) >> 1);
   assign odd_prod  = 19'(half_len) * 19'(repeat_count_ff);
   assign even_prod = 20'(eff_len) * 20'(repeat_count_ff);
   always_comb begin
      if (repeat_count_ff == isst_pkg::REP_W'(1))
         span_end = isst_pkg::CNT_W'(eff_len);
      else if (repeat_count_ff[0])
         span_end = isst_pkg::CNT_W'(odd_prod) - isst_pkg::CNT_W'(1);
      else
         span_end = isst_pkg::CNT_W'(even_prod >> 1);
   end

   always_comb begin
      enabled_in       = enabled_ff;
      started_in       = started_ff;
      delay_entered_in = delay_entered_ff;
      cycle_in         = cycle_ff;
      suspended_in     = suspended_ff;
      ended_in         = ended_ff;
      level_in         = level_ff;
      entry_in         = entry_ff;
      index_in         = index_ff;
      exec_in          = exec_ff;
      interval_in      = interval_ff;
      sleep_in         = sleep_ff;
      repeat_in        = repeat_ff;
      run_in           = 1'b0;
      hold             = 1'b0;
      do_clear         = 1'b0;

      unique case (req_func)
         isst_pkg::FUNC_CALL: begin
            if (enabled_ff) begin
               // start delay
               if (!started_ff && start_delay_ff != '0) begin
                  if (!delay_entered_ff) begin
                     entry_in         = req_now_us;
                     delay_entered_in = 1'b1;
                     hold             = 1'b1;
                  end else if (elapsed < start_delay_ff) begin
                     hold = 1'b1;
                  end else begin
                     started_in = 1'b1;
                     if (spanning) level_in = 1'b1;
                  end
               end

               if (!hold && !spanning) begin
                  if (!cycle_ff) begin
                     entry_in         = req_now_us;
                     delay_entered_in = 1'b1;
                     cycle_in         = 1'b1;
                     if (suspended_ff) begin
                        sleep_in = sleep_ff + isst_pkg::CNT_W'(1);
                     end else if (finite && repeat_ff >= repeat_count_ff) begin
                        if (mode_ff[isst_pkg::MODE_SUSP_END]) suspended_in = 1'b1;
                        else do_clear = 1'b1;
                        ended_in = 1'b1;
                        sleep_in = '0;
                     end else begin
                        exec_in = exec_ff + isst_pkg::CNT_W'(1);
                        run_in  = 1'b1;
                     end
                  end else if (interval_done) begin
                     index_in = next_index;
                     if (wrapped && !suspended_ff && repeat_ff != isst_pkg::REP_MAX)
                        repeat_in = repeat_ff + isst_pkg::REP_W'(1);
                     cycle_in = 1'b0;
                  end
               end else if (!hold) begin
                  if (!cycle_ff) begin
                     level_in         = 1'b1;
                     exec_in          = exec_ff + isst_pkg::CNT_W'(1);
                     entry_in         = req_now_us;
                     delay_entered_in = 1'b1;
                     cycle_in         = 1'b1;
                     ended_in         = 1'b0;
                     started_in       = 1'b1;
                     index_in         = '0;
                     interval_in      = '0;
                     run_in           = ~suspended_ff;
                  end else if (interval_done) begin
                     index_in         = next_index;
                     interval_in      = interval_ff + isst_pkg::CNT_W'(1);
                     entry_in         = req_now_us;
                     delay_entered_in = 1'b1;
                     if (suspended_ff) begin
                        sleep_in = sleep_ff + isst_pkg::CNT_W'(1);
                        level_in = ~level_in;
                     end else if (finite && exec_ff >= span_end) begin
                        if (mode_ff[isst_pkg::MODE_SUSP_END]) suspended_in = 1'b1;
                        else do_clear = 1'b1;
                        level_in = 1'b0;
                        ended_in = 1'b1;
                        sleep_in = '0;
                     end else begin
                        level_in = ~level_in;
                        if (level_in) exec_in = exec_ff + isst_pkg::CNT_W'(1);
                        run_in = level_in;
                     end
                  end else begin
                     run_in = ~suspended_ff & level_in;
                  end
               end
            end
         end
         isst_pkg::FUNC_ENABLE:  enabled_in   = 1'b1;
         isst_pkg::FUNC_DISABLE: do_clear     = 1'b1;
         isst_pkg::FUNC_SUSPEND: suspended_in = 1'b1;
         isst_pkg::FUNC_RESUME:  suspended_in = 1'b0;
         isst_pkg::FUNC_RESET:   do_clear     = 1'b1;
         default: ;
      endcase

      // disable, reset or an end of run without suspend-at-end: clears the timer state and marks the run as ended
      if (do_clear) begin
         enabled_in       = 1'b0;
         started_in       = 1'b0;
         cycle_in         = 1'b0;
         suspended_in     = 1'b0;
         ended_in         = 1'b1;
         level_in         = 1'b0;
         delay_entered_in = 1'b0;
         entry_in         = '0;
         index_in         = '0;
         exec_in          = '0;
         interval_in      = '0;
         sleep_in         = '0;
         repeat_in        = '0;
      end
      if (req_func == isst_pkg::FUNC_RESET) enabled_in = 1'b1;
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= '0;
         seq_length_ff    <= isst_pkg::LEN_W'(1);
         repeat_count_ff  <= '0;
         start_delay_ff   <= '0;
         for (int e = 0; e < TABLE_DEPTH; e++) table_ff[e] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            isst_pkg::REG_MODE:         mode_ff         <= csr_data[1:0];
            isst_pkg::REG_SEQ_LENGTH:   seq_length_ff   <= csr_data[isst_pkg::LEN_W-1:0];
            isst_pkg::REG_REPEAT_COUNT: repeat_count_ff <= csr_data[isst_pkg::REP_W-1:0];
            isst_pkg::REG_START_DELAY:  start_delay_ff  <= csr_data[isst_pkg::TIME_W-1:0];
            default: begin
               // interval pairs: even entry in the low half, odd in the high half
               for (int e = 0; e < TABLE_DEPTH; e++) begin
                  if (csr_index == isst_pkg::REG_INTERVALS_01 + isst_pkg::CSR_IDX_W'(e / 2))
                     table_ff[e] <= csr_data[isst_pkg::TIME_W*(e % 2) +: isst_pkg::TIME_W];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff       <= 1'b1;
         started_ff       <= 1'b0;
         delay_entered_ff <= 1'b0;
         cycle_ff         <= 1'b0;
         suspended_ff     <= 1'b0;
         ended_ff         <= 1'b0;
         level_ff         <= 1'b0;
         entry_ff         <= '0;
         index_ff         <= '0;
         exec_ff          <= '0;
         interval_ff      <= '0;
         sleep_ff         <= '0;
         repeat_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            enabled_ff       <= enabled_in;
            started_ff       <= started_in;
            delay_entered_ff <= delay_entered_in;
            cycle_ff         <= cycle_in;
            suspended_ff     <= suspended_in;
            ended_ff         <= ended_in;
            level_ff         <= level_in;
            entry_ff         <= entry_in;
            index_ff         <= index_in;
            exec_ff          <= exec_in;
            interval_ff      <= interval_in;
            sleep_ff         <= sleep_in;
            repeat_ff        <= repeat_in;
         end
      end
   end

   // result word payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_run_ff       <= run_in;
         rsp_enabled_ff   <= enabled_in;
         rsp_suspended_ff <= suspended_in;
         rsp_ended_ff     <= ended_in;
         rsp_position_ff  <= index_in;
         rsp_exec_ff      <= exec_in;
         rsp_interval_ff  <= interval_in;
         rsp_sleep_ff     <= sleep_in;
         rsp_repeat_ff    <= repeat_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_run            = rsp_run_ff;
   assign rsp_is_enabled     = rsp_enabled_ff;
   assign rsp_is_suspended   = rsp_suspended_ff;
   assign rsp_has_ended      = rsp_ended_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_exec_total     = rsp_exec_ff;
   assign rsp_interval_total = rsp_interval_ff;
   assign rsp_sleep_total    = rsp_sleep_ff;
   assign rsp_repeat_total   = rsp_repeat_ff;

endmodule

/* dv/tb.sv */
// Self-checking testbench for the interval sequence task timer.
module tb;

   localparam logic [isst_pkg::FUNC_W-1:0]    FUNC_SPARE_A     = 3'd6;
   localparam logic [isst_pkg::FUNC_W-1:0]    FUNC_SPARE_B     = 3'd7;
   localparam logic [isst_pkg::CSR_IDX_W-1:0] REG_INTERVALS_23 = 3'd5;
   localparam logic [isst_pkg::CSR_IDX_W-1:0] REG_INTERVALS_45 = 3'd6;
   localparam logic [isst_pkg::CSR_IDX_W-1:0] REG_INTERVALS_67 = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT     = 500;
   localparam int HOLD_LEN    = 60;

   typedef struct {
      logic [isst_pkg::FUNC_W-1:0] func;
      logic [isst_pkg::TIME_W-1:0] now;
      bit                          drain;
   } timer_req_type;

   typedef struct {
      logic                       run;
      logic                       en;
      logic                       susp;
      logic                       ended;
      logic [isst_pkg::POS_W-1:0] pos;
      logic [isst_pkg::CNT_W-1:0] n_exec;
      logic [isst_pkg::CNT_W-1:0] n_intv;
      logic [isst_pkg::CNT_W-1:0] n_sleep;
      logic [isst_pkg::REP_W-1:0] n_rep;
   } timer_rsp_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [isst_pkg::FUNC_W-1:0]     req_func = isst_pkg::FUNC_CALL;
   logic [isst_pkg::TIME_W-1:0]     req_now_us = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_run;
   logic                            rsp_is_enabled;
   logic                            rsp_is_suspended;
   logic                            rsp_has_ended;
   logic [isst_pkg::POS_W-1:0]      rsp_position;
   logic [isst_pkg::CNT_W-1:0]      rsp_exec_total;
   logic [isst_pkg::CNT_W-1:0]      rsp_interval_total;
   logic [isst_pkg::CNT_W-1:0]      rsp_sleep_total;
   logic [isst_pkg::REP_W-1:0]      rsp_repeat_total;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [isst_pkg::CSR_IDX_W-1:0]  csr_index = isst_pkg::REG_MODE;
   logic [isst_pkg::CSR_DATA_W-1:0] csr_data = '0;

   interval_sequence_task_timer dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // configuration copy
   logic [1:0]                  cfg_mode;
   logic [isst_pkg::LEN_W-1:0]  cfg_len;
   logic [isst_pkg::REP_W-1:0]  cfg_repeat;
   logic [isst_pkg::TIME_W-1:0] cfg_delay;
   logic [isst_pkg::TIME_W-1:0] span_us [8];

   // timer state copy
   bit                          en_f, started_f, delay_f, cycle_f, susp_f, ended_f, level_f;
   logic [isst_pkg::TIME_W-1:0] entry_t;
   logic [isst_pkg::POS_W-1:0]  pos;
   logic [isst_pkg::CNT_W-1:0]  n_exec, n_intv, n_sleep;
   logic [isst_pkg::REP_W-1:0]  n_rep;

   timer_req_type req_plan [$];
   timer_rsp_type rsp_due [$];
   int            n_errors = 0;
   int            n_checked = 0;
   int            n_cycles = 0;
   bit            tx_burst = 1'b0;
   bit            rx_burst = 1'b0;
   bit            rx_hold = 1'b0;

   // plan for the next phase
   logic [1:0]                  p_mode;
   logic [isst_pkg::LEN_W-1:0]  p_len;
   logic [isst_pkg::REP_W-1:0]  p_rep;
   logic [isst_pkg::TIME_W-1:0] p_dly;
   logic [isst_pkg::TIME_W-1:0] p_span [8];
   logic [isst_pkg::TIME_W-1:0] wall_us;

   function automatic int timer_len();
      if (cfg_len == 0) return 1;
      if (cfg_len > 8) return 8;
      return int'(cfg_len);
   endfunction

   function automatic void timer_clear();
      en_f = 0; started_f = 0; cycle_f = 0; susp_f = 0; ended_f = 1; level_f = 0;
      delay_f = 0; entry_t = '0; pos = '0;
      n_exec = '0; n_intv = '0; n_sleep = '0; n_rep = '0;
   endfunction

   function automatic void timer_power_on();
      cfg_mode = '0; cfg_len = isst_pkg::LEN_W'(1); cfg_repeat = '0; cfg_delay = '0;
      foreach (span_us[i]) span_us[i] = '0;
      timer_clear();
      en_f = 1; ended_f = 0;
   endfunction

   function automatic void timer_cfg_write(logic [isst_pkg::CSR_IDX_W-1:0] idx,
                                           logic [isst_pkg::CSR_DATA_W-1:0] val);
      int k;
      case (idx)
         isst_pkg::REG_MODE:         cfg_mode = val[1:0];
         isst_pkg::REG_SEQ_LENGTH:   cfg_len = val[isst_pkg::LEN_W-1:0];
         isst_pkg::REG_REPEAT_COUNT: cfg_repeat = val[isst_pkg::REP_W-1:0];
         isst_pkg::REG_START_DELAY:  cfg_delay = val[31:0];
         default: begin
            k = 2 * int'(idx - isst_pkg::REG_INTERVALS_01);
            span_us[k]   = val[31:0];
            span_us[k+1] = val[63:32];
         end
      endcase
   endfunction

   function automatic void timer_sleep();
      if (cfg_mode[isst_pkg::MODE_SUSP_END]) susp_f = 1;
      else timer_clear();
   endfunction

   // returns 1 when the position wrapped to 0
   function automatic bit timer_advance();
      if (int'(pos) < timer_len() - 1) begin
         pos = pos + 1'b1;
         return 0;
      end
      pos = '0;
      return 1;
   endfunction

   // returns 1 while the start delay holds the task back
   function automatic bit timer_delay_hold(logic [isst_pkg::TIME_W-1:0] now, bit spanning);
      logic [isst_pkg::TIME_W-1:0] el;
      if (started_f || cfg_delay == 0) return 0;
      if (!delay_f) begin
         entry_t = now; delay_f = 1;
         return 1;
      end
      el = now - entry_t;
      if (el < cfg_delay) return 1;
      started_f = 1;
      if (spanning) level_f = 1;
      return 0;
   endfunction

   function automatic bit timer_oneshot(logic [isst_pkg::TIME_W-1:0] now);
      logic [isst_pkg::TIME_W-1:0] el;
      bit wrapped;
      if (timer_delay_hold(now, 1'b0)) return 0;
      if (!cycle_f) begin
         entry_t = now; delay_f = 1; cycle_f = 1;
         if (susp_f) begin
            n_sleep++;
            return 0;
         end
         if (cfg_repeat > 0 && n_rep >= cfg_repeat) begin
            timer_sleep();
            ended_f = 1; n_sleep = '0;
            return 0;
         end
         n_exec++;
         return 1;
      end
      el = now - entry_t;
      if (el < span_us[pos]) return 0;
      wrapped = timer_advance();
      if (wrapped && !susp_f && n_rep != isst_pkg::REP_MAX) n_rep++;
      cycle_f = 0;
      return 0;
   endfunction

   function automatic logic [isst_pkg::CNT_W-1:0] timer_span_limit();
      logic [isst_pkg::CNT_W-1:0] len, r;
      len = isst_pkg::CNT_W'(timer_len());
      r = isst_pkg::CNT_W'(cfg_repeat);
      if (r == 1) return len;
      if (r[0]) return ((len + 1) / 2) * r - 1;
      return (len * r) / 2;
   endfunction

   function automatic bit timer_spanning(logic [isst_pkg::TIME_W-1:0] now);
      logic [isst_pkg::TIME_W-1:0] el;
      if (timer_delay_hold(now, 1'b1)) return 0;
      el = now - entry_t;
      if (!cycle_f) begin
         level_f = 1; n_exec++; entry_t = now; delay_f = 1; cycle_f = 1;
         ended_f = 0; started_f = 1; pos = '0; n_intv = '0;
      end else if (el >= span_us[pos]) begin
         void'(timer_advance());
         n_intv++; entry_t = now; delay_f = 1;
         if (susp_f) begin
            n_sleep++; level_f = !level_f;
            return 0;
         end
         if (cfg_repeat > 0 && n_exec >= timer_span_limit()) begin
            timer_sleep();
            level_f = 0; ended_f = 1; n_sleep = '0;
            return 0;
         end
         level_f = !level_f;
         if (level_f) n_exec++;
      end
      return susp_f ? 1'b0 : level_f;
   endfunction

   function automatic timer_rsp_type timer_predict(timer_req_type r);
      timer_rsp_type o;
      o.run = 1'b0;
      case (r.func)
         isst_pkg::FUNC_CALL:
            if (en_f) o.run = cfg_mode[isst_pkg::MODE_SPANNING] ? timer_spanning(r.now)
                                                                : timer_oneshot(r.now);
         isst_pkg::FUNC_ENABLE:  en_f = 1;
         isst_pkg::FUNC_DISABLE: timer_clear();
         isst_pkg::FUNC_SUSPEND: susp_f = 1;
         isst_pkg::FUNC_RESUME:  susp_f = 0;
         isst_pkg::FUNC_RESET: begin
            timer_clear();
            en_f = 1;
         end
         default: ;
      endcase
      o.en = en_f; o.susp = susp_f; o.ended = ended_f; o.pos = pos;
      o.n_exec = n_exec; o.n_intv = n_intv; o.n_sleep = n_sleep; o.n_rep = n_rep;
      return o;
   endfunction

   function automatic void flag_error(string what);
      n_errors++;
      if (n_errors <= 10) $display("tb: %s", what);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
         flag_error($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
   endfunction

   // driver: one word in flight, per-word gap drawn when it is loaded
   always @(posedge clock) begin : drive_proc
      timer_req_type cur;
      int send_gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) rsp_due.push_back(timer_predict(cur));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (req_plan.size() > 0 &&
                         !(req_plan[0].drain && rsp_due.size() > 0)) begin
               cur = req_plan.pop_front();
               req_valid  <= 1'b1;
               req_func   <= cur.func;
               req_now_us <= cur.now;
               send_gap = tx_burst ? 0 : $urandom_range(0, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long back-pressure stretch so the input side fills and stalls
   always @(posedge clock) begin : hold_proc
      int hold_left;
      bit hold_done;
      if (reset) begin
         rx_hold <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (!hold_done && n_checked >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rx_hold <= 1'b1;
         end else begin
            rx_hold <= 1'b0;
         end
      end
   end

   // monitor: checks each result word, draws its own stall per word
   always @(posedge clock) begin : watch_proc
      timer_rsp_type w;
      int stall_wait;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               flag_error("result word with nothing pending");
            end else begin
               w = rsp_due.pop_front();
               check_field("run", 32'(w.run), 32'(rsp_run));
               check_field("is_enabled", 32'(w.en), 32'(rsp_is_enabled));
               check_field("is_suspended", 32'(w.susp), 32'(rsp_is_suspended));
               check_field("has_ended", 32'(w.ended), 32'(rsp_has_ended));
               check_field("position", 32'(w.pos), 32'(rsp_position));
               check_field("exec_total", w.n_exec, rsp_exec_total);
               check_field("interval_total", w.n_intv, rsp_interval_total);
               check_field("sleep_total", w.n_sleep, rsp_sleep_total);
               check_field("repeat_total", 32'(w.n_rep), 32'(rsp_repeat_total));
            end
            n_checked++;
            stall_wait = rx_burst ? 0 : $urandom_range(0, 5);
         end
         if (rx_hold) begin
            rsp_stall <= 1'b1;
         end else if (stall_wait > 0) begin
            stall_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic push_word(logic [isst_pkg::FUNC_W-1:0] func,
                            logic [isst_pkg::TIME_W-1:0] now, bit drain);
      timer_req_type r;
      r.func = func; r.now = now; r.drain = drain;
      req_plan.push_back(r);
   endtask

   task automatic csr_write(logic [isst_pkg::CSR_IDX_W-1:0] idx,
                            logic [isst_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      timer_cfg_write(idx, val);
   endtask

   task automatic load_plan();
      csr_write(isst_pkg::REG_MODE, isst_pkg::CSR_DATA_W'(p_mode));
      csr_write(isst_pkg::REG_SEQ_LENGTH, isst_pkg::CSR_DATA_W'(p_len));
      csr_write(isst_pkg::REG_REPEAT_COUNT, isst_pkg::CSR_DATA_W'(p_rep));
      csr_write(isst_pkg::REG_START_DELAY, isst_pkg::CSR_DATA_W'(p_dly));
      csr_write(isst_pkg::REG_INTERVALS_01, {p_span[1], p_span[0]});
      csr_write(REG_INTERVALS_23, {p_span[3], p_span[2]});
      csr_write(REG_INTERVALS_45, {p_span[5], p_span[4]});
      csr_write(REG_INTERVALS_67, {p_span[7], p_span[6]});
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      while (req_plan.size() != 0 || req_valid || rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [isst_pkg::TIME_W-1:0] pick_span();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return $urandom;
      return $urandom_range(1, 40);
   endfunction

   task automatic random_phase(int ph, int n_words);
      int r, step_max;
      p_mode[isst_pkg::MODE_SPANNING] = ph[0];
      p_mode[isst_pkg::MODE_SUSP_END] = ph[1];
      r = $urandom_range(0, 9);
      if (ph == 0) p_len = isst_pkg::LEN_W'(0);
      else if (ph == 1) p_len = isst_pkg::LEN_W'(15);
      else if (ph == 4) p_len = isst_pkg::LEN_W'(8);
      else p_len = (r < 2) ? isst_pkg::LEN_W'($urandom_range(9, 15))
                           : isst_pkg::LEN_W'($urandom_range(1, 8));
      r = $urandom_range(0, 9);
      if (ph == 3) p_rep = isst_pkg::REP_MAX;
      else if (ph == 2) p_rep = isst_pkg::REP_W'(1);
      else if (r < 3) p_rep = '0;
      else if (r < 9) p_rep = isst_pkg::REP_W'($urandom_range(1, 4));
      else p_rep = isst_pkg::REP_W'($urandom_range(5, 65535));
      r = $urandom_range(0, 9);
      if (ph == 1) p_dly = '1;
      else p_dly = (r < 5) ? '0 : isst_pkg::TIME_W'($urandom_range(1, 60));
      foreach (p_span[i]) p_span[i] = pick_span();
      if (ph == 6) p_span[0] = '1;
      load_plan();

      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      step_max = $urandom_range(1, 15);
      wall_us = (ph == 5) ? 32'hFFFF_FF00 : $urandom;
      if (ph < 3 || $urandom_range(0, 1) == 1) push_word(isst_pkg::FUNC_RESET, wall_us, 1'b0);
      for (int i = 0; i < n_words; i++) begin
         wall_us += $urandom_range(0, step_max);
         r = $urandom_range(0, 99);
         // mostly calls on a running clock, some commands and stray times
         if (r < 4) push_word(isst_pkg::FUNC_ENABLE, $urandom, 1'b0);
         else if (r < 6) push_word(isst_pkg::FUNC_RESET, $urandom, 1'b0);
         else if (r < 8) push_word(isst_pkg::FUNC_SUSPEND, $urandom, 1'b0);
         else if (r < 10) push_word(isst_pkg::FUNC_RESUME, $urandom, 1'b0);
         else if (r < 11) push_word(isst_pkg::FUNC_DISABLE, $urandom, 1'b0);
         else if (r < 12) push_word(r[0] ? FUNC_SPARE_A : FUNC_SPARE_B, $urandom, 1'b0);
         else if (r < 14) push_word(isst_pkg::FUNC_CALL, $urandom, 1'b0);
         else push_word(isst_pkg::FUNC_CALL, wall_us, (i % 40) == 39);
      end
      settle();
   endtask

   initial begin
      timer_power_on();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: zero intervals, oneshot, endless
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0000, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'hFFFF_FFFF, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0000, 1'b0);
      push_word(isst_pkg::FUNC_SUSPEND, 32'h0, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0001, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0002, 1'b0);
      push_word(isst_pkg::FUNC_RESUME, 32'h0, 1'b0);
      push_word(FUNC_SPARE_A, 32'hFFFF_FFFF, 1'b0);
      push_word(FUNC_SPARE_B, 32'h0, 1'b0);
      push_word(isst_pkg::FUNC_DISABLE, 32'h0, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0005, 1'b0);
      push_word(isst_pkg::FUNC_ENABLE, 32'h0, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'hFFFF_FFFF, 1'b0);
      push_word(isst_pkg::FUNC_RESET, 32'h0, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0000, 1'b0);
      settle();

      // spanning, length zero, start delay across the time wrap, longest interval
      p_mode = '0;
      p_mode[isst_pkg::MODE_SPANNING] = 1'b1;
      p_len = '0;
      p_rep = isst_pkg::REP_MAX;
      p_dly = 3;
      foreach (p_span[i]) p_span[i] = '0;
      p_span[0] = '1;
      load_plan();
      push_word(isst_pkg::FUNC_RESET, 32'h0, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'hFFFF_FFFE, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0000, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0001, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0005, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'h0000_0000, 1'b0);
      push_word(isst_pkg::FUNC_SUSPEND, 32'h0, 1'b0);
      push_word(isst_pkg::FUNC_CALL, 32'hFFFF_FFFF, 1'b0);
      push_word(isst_pkg::FUNC_RESUME, 32'h0, 1'b0);
      settle();

      for (int ph = 0; ph < 16; ph++) random_phase(ph, 100);

      repeat (10) @(posedge clock);
      if (rsp_due.size() != 0) flag_error("results still pending at end");
      if (n_errors == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule
